// ----- sv/b64_pkg.sv -----
package b64_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // one closed group, ready to be emitted
  typedef struct packed {
    logic        dir;
    logic [23:0] bits;
    logic [2:0]  nout;   // words to emit, 1..4
    logic [2:0]  nreal;  // encode: leading non-pad characters
    logic        last;
  } b64_job_t;

  function automatic logic [7:0] to_char(input logic [5:0] x);
    logic [7:0] r;
    if (x < 6'd26) begin
      r = 8'h41 + {2'b00, x};
    end else if (x < 6'd52) begin
      r = 8'h61 + {2'b00, x - 6'd26};
    end else if (x < 6'd62) begin
      r = 8'h30 + {2'b00, x - 6'd52};
    end else if (x == 6'd62) begin
      r = PLUS_CHAR;
    end else begin
      r = SLASH_CHAR;
    end
    return r;
  endfunction

  function automatic logic [5:0] from_char(input logic [7:0] c);
    logic [7:0] r;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = c - 8'h61 + 8'd26;
    end else if (c inside {[8'h30:8'h39]}) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == PLUS_CHAR) begin
      r = 8'd62;
    end else if (c == SLASH_CHAR) begin
      r = 8'd63;
    end else begin
      r = 8'd0;
    end
    return r[5:0];
  endfunction

endpackage

// ----- sv/b64_front.sv -----
module b64_front import b64_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     in_stall,
  output logic     q_push,
  output b64_job_t q_job
);

  logic        dir_r;
  logic [23:0] grp_r, grp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pad3_r, pad3_nxt;

  logic        acc;
  logic        complete;
  logic [2:0]  n;
  logic [23:0] bits;
  logic [5:0]  six;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign n        = {1'b0, cnt_r} + 3'd1;
  assign six      = from_char(in_word.in_byte);

  always_comb begin
    grp_nxt    = grp_r;
    cnt_nxt    = cnt_r;
    pad3_nxt   = pad3_r;
    complete   = 1'b0;
    bits       = '0;
    q_job.dir  = dir_r;
    q_job.bits = '0;
    q_job.nout = 3'd0;
    q_job.nreal = 3'd0;
    q_job.last = in_word.is_last;
    if (dir_r == DIR_ENCODE) begin
      bits     = {grp_r[15:0], in_word.in_byte};
      complete = (n == 3'd3) || in_word.is_last;
      case (n)
        3'd1:    q_job.bits = {bits[7:0], 16'h0000};
        3'd2:    q_job.bits = {bits[15:0], 8'h00};
        default: q_job.bits = bits;
      endcase
      q_job.nout  = 3'd4;
      q_job.nreal = n + 3'd1;
    end else begin
      bits     = {grp_r[17:0], six};
      complete = (n == 3'd4) || in_word.is_last;
      if (n == 3'd3) begin
        pad3_nxt = (in_word.in_byte == PAD_CHAR);
      end
      case (n)
        3'd1: begin
          q_job.bits = {bits[5:0], 18'h00000};
          q_job.nout = 3'd0;
        end
        3'd2: begin
          q_job.bits = {bits[11:0], 12'h000};
          q_job.nout = 3'd1;
        end
        3'd3: begin
          q_job.bits = {bits[17:0], 6'h00};
          q_job.nout = 3'd2;
        end
        default: begin
          q_job.bits = bits;
          if (in_word.is_last && pad3_r) begin
            q_job.nout = 3'd1;
          end else if (in_word.is_last && in_word.in_byte == PAD_CHAR) begin
            q_job.nout = 3'd2;
          end else begin
            q_job.nout = 3'd3;
          end
        end
      endcase
      q_job.nreal = q_job.nout;
    end
    if (acc) begin
      if (complete) begin
        grp_nxt  = '0;
        cnt_nxt  = '0;
        pad3_nxt = 1'b0;
      end else begin
        grp_nxt = bits;
        cnt_nxt = n[1:0];
      end
    end else begin
      pad3_nxt = pad3_r;
    end
  end

  assign q_push = acc && complete && (q_job.nout != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r  <= DIR_ENCODE;
      grp_r  <= '0;
      cnt_r  <= '0;
      pad3_r <= 1'b0;
    end else if (cfg_we) begin
      dir_r  <= cfg_wdata;
      grp_r  <= '0;
      cnt_r  <= '0;
      pad3_r <= 1'b0;
    end else begin
      grp_r  <= grp_nxt;
      cnt_r  <= cnt_nxt;
      pad3_r <= pad3_nxt;
    end
  end

endmodule

// ----- sv/b64_queue.sv -----
module b64_queue import b64_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  b64_job_t wdata,
  input  logic     pop,
  output b64_job_t rdata,
  output logic     full,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64_job_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- sv/b64_back.sv -----
module b64_back import b64_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  b64_job_t  q_job,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  b64_job_t   job_r, job_nxt;
  logic       vld_r, vld_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       take;
  logic       done;
  logic [1:0] last_idx;
  logic [5:0] six;
  logic [2:0] idx_w;

  assign last_idx  = 2'(job_r.nout - 3'd1);
  assign take      = vld_r && !out_stall;
  assign done      = take && (idx_r == last_idx);
  assign q_pop     = (!vld_r || done) && !q_empty;
  assign out_valid = vld_r;
  assign idx_w     = {1'b0, idx_r};

  always_comb begin
    case (idx_r)
      2'd0:    six = job_r.bits[23:18];
      2'd1:    six = job_r.bits[17:12];
      2'd2:    six = job_r.bits[11:6];
      default: six = job_r.bits[5:0];
    endcase
    if (job_r.dir == DIR_ENCODE) begin
      out_word.out_byte = (idx_w < job_r.nreal) ? to_char(six) : PAD_CHAR;
    end else begin
      case (idx_r)
        2'd0:    out_word.out_byte = job_r.bits[23:16];
        2'd1:    out_word.out_byte = job_r.bits[15:8];
        default: out_word.out_byte = job_r.bits[7:0];
      endcase
    end
    out_word.out_last = job_r.last && (idx_r == last_idx);
  end

  always_comb begin
    job_nxt = job_r;
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (q_pop) begin
      job_nxt = q_job;
      vld_nxt = 1'b1;
      idx_nxt = '0;
    end else if (done) begin
      vld_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- sv/base64_stream_codec.sv -----
// Base64 codec, standard alphabet. cfg_wdata written with cfg_we selects
// encode (0) or decode (1) and clears any partial group. An input word is
// taken every cycle while the job queue (QueueDepth closed groups) has room;
// the emitter drives one result word per cycle while out_stall is low, so
// encode is bounded by the emitter, four characters per three input bytes,
// and decode by the input side. A group's closing word is written into the
// job queue, then the emitter loads the group into its register and drives
// its first result. Padding '=' only counts in the group closed by is_last.
module base64_stream_codec import b64_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  b64_job_t push_job;
  b64_job_t pop_job;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_job),
    .pop   (q_pop),
    .rdata (pop_job),
    .full  (q_full),
    .empty (q_empty)
  );

  b64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (pop_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ----- sv/b64_checker.sv -----
module b64_checker import b64_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  a_rst_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // a word cannot reach the output of an empty block without an input word before it
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && !out_valid |=> !out_valid || $past(in_valid))
    else $error("result appeared without any input word");

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
